@@ hw/rtl/bsr_pkg.sv @@
// Shared types, constants and helper functions for the brush stroke rasteriser.
// Used by every module under hw/rtl except bsr_ram; depends on nothing.
package bsr_pkg;

	// Frame and brush limits
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_RADIUS = 63;

	localparam int FB_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W   = $clog2(FB_DEPTH);
	localparam int XY_W     = 8;   // on-frame column or row index
	localparam int SIZE_W   = 9;   // frame size register
	localparam int IN_W     = 12;  // coordinate fields
	localparam int DELTA_W  = 13;  // signed end minus start
	localparam int MAG_W    = 12;  // magnitude of a delta
	localparam int COORD_W  = 14;  // pass pixel, may run off-frame
	localparam int RAD_W    = 6;
	localparam int AB_W     = 7;   // midpoint circle a and b
	localparam int DISC_D_W = 12;  // midpoint circle decision
	localparam int PIX_W    = 32;

	// Midpoint circle constants
	localparam int DISC_D0  = 3;
	localparam int DISC_DEC = 10;
	localparam int DISC_INC = 6;
	localparam int DISC_MUL = 4;

	// Command codes
	localparam logic [1:0] FN_STROKE = 2'd0;
	localparam logic [1:0] FN_WRITE  = 2'd1;
	localparam logic [1:0] FN_READ   = 2'd2;

	// Configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic             req;
		logic [MAG_W-1:0] num;
		logic [MAG_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] quo;
		logic [MAG_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic                      valid;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} pix_t;

	// Saturate a written size to 1..max
	function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] mx);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > mx) begin
			r = mx;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Pixel lies inside the active frame
	function automatic logic in_frame(input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y, input logic [SIZE_W-1:0] w,
		input logic [SIZE_W-1:0] h);
		logic ok;
		ok = !x[COORD_W-1] && (x[COORD_W-2:0] < (COORD_W-1)'(w)) &&
			!y[COORD_W-1] && (y[COORD_W-2:0] < (COORD_W-1)'(h));
		return ok;
	endfunction

endpackage

@@ hw/rtl/brush_stroke_rasterizer_top.sv @@
// Top level of the brush stroke rasteriser: command sequencer, disc walker,
// write path and frame store. Depends on bsr_pkg, bsr_ram, bsr_div, bsr_line_step.

// Commands are taken when start is high and busy is low; one result beat
// follows on done with read_value (zero for anything but a pixel read), and
// it must be taken in that cycle. A stroke runs, per non-empty pass, a
// division and then the pass pixels. With the brush on and a non-zero radius,
// each on-frame pass pixel adds a disc of roughly 8 * (0.71 * radius + 1)
// spoke lines, each stepped like a stroke with a division per non-empty pass.
// The single frame store write port, which takes one pixel a cycle, and the
// one divider are shared by all passes. The frame store is not cleared after
// reset.
module brush_stroke_rasterizer_top
	import bsr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	output logic                   done,
	input  logic [1:0]             func,
	input  logic signed [IN_W-1:0] end_x,
	input  logic signed [IN_W-1:0] end_y,
	input  logic signed [IN_W-1:0] start_x,
	input  logic signed [IN_W-1:0] start_y,
	input  logic [RAD_W-1:0]       brush_radius,
	input  logic                   brush_enable,
	input  logic [PIX_W-1:0]       color,
	output logic [PIX_W-1:0]       read_value,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [SIZE_W-1:0]      cfg_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CMD   = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_END   = 4'd3;
	localparam logic [3:0] ST_OSTRT = 4'd4;
	localparam logic [3:0] ST_ORUN  = 4'd5;
	localparam logic [3:0] ST_DINIT = 4'd6;
	localparam logic [3:0] ST_DLINE = 4'd7;
	localparam logic [3:0] ST_DWAIT = 4'd8;
	localparam logic [3:0] ST_DSTEP = 4'd9;
	localparam logic [3:0] ST_DEND  = 4'd10;
	localparam logic [3:0] ST_DONE  = 4'd11;

	localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);
	localparam int PROD_W = XY_W + SIZE_W;

	logic [3:0]            state_q;
	logic [SIZE_W-1:0]     w_q, h_q;
	logic [1:0]            func_q;
	logic signed [IN_W-1:0] ex_q, ey_q, sx_q, sy_q;
	logic [RAD_W-1:0]      r_q;
	logic                  brush_q;
	logic [PIX_W-1:0]      color_q;
	logic [PIX_W-1:0]      result_q;
	logic                  rd_on_q;
	logic [XY_W-1:0]       ecx_q, ecy_q;
	logic [XY_W-1:0]       cx_q, cy_q;
	logic [AB_W-1:0]       a_q, b_q;
	logic signed [DISC_D_W-1:0] d_q;
	logic [2:0]            oct_q;

	// Command decode
	logic signed [COORD_W-1:0] exe, eye, sxe, sye, ecx, ecy;
	logic                      zero_len, start_on, end_on;
	logic [COORD_W-1:0]        wm1, hm1;

	// Write path
	logic signed [COORD_W-1:0] wr_x, wr_y;
	logic                      wr_on, wr_sel, ram_we, ram_re;
	logic [PROD_W-1:0]         addr_full;
	logic [ADDR_W-1:0]         addr;
	logic [PIX_W-1:0]          ram_rdata;

	// Steppers and divider
	pix_t                      opix, ipix;
	logic                      o_busy, i_busy, o_adv, o_start, i_start;
	div_req_t                  o_div, i_div, div_req;
	div_rsp_t                  div_rsp;
	logic signed [DELTA_W-1:0] odx, ody;
	logic signed [COORD_W-1:0] ox, oy, isx, isy;
	logic signed [DELTA_W-1:0] idx, idy;
	logic [AB_W-1:0]           omx, omy;
	logic signed [DISC_D_W-1:0] d_dec, d_inc;
	logic                      brush_hit;

	// Configuration writes, saturated as they land
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= MAX_W_SZ;
			h_q <= MAX_H_SZ;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  w_q <= sat_size(cfg_data, MAX_W_SZ);
				REG_HEIGHT: h_q <= sat_size(cfg_data, MAX_H_SZ);
				default:    w_q <= w_q;
			endcase
		end
	end

	// Sign-extend the latched command and clamp the end point when the start is on frame
	assign exe = {{(COORD_W-IN_W){ex_q[IN_W-1]}}, ex_q};
	assign eye = {{(COORD_W-IN_W){ey_q[IN_W-1]}}, ey_q};
	assign sxe = {{(COORD_W-IN_W){sx_q[IN_W-1]}}, sx_q};
	assign sye = {{(COORD_W-IN_W){sy_q[IN_W-1]}}, sy_q};
	assign wm1 = COORD_W'(w_q) - 1'b1;
	assign hm1 = COORD_W'(h_q) - 1'b1;

	assign zero_len = (ex_q == sx_q) && (ey_q == sy_q);
	assign start_on = in_frame(sxe, sye, w_q, h_q);

	always_comb begin
		ecx = exe;
		ecy = eye;
		if (start_on) begin
			if (exe[COORD_W-1]) begin
				ecx = '0;
			end else if (exe >= $signed(COORD_W'(w_q))) begin
				ecx = $signed(wm1);
			end
			if (eye[COORD_W-1]) begin
				ecy = '0;
			end else if (eye >= $signed(COORD_W'(h_q))) begin
				ecy = $signed(hm1);
			end
		end
	end
	assign end_on = in_frame(ecx, ecy, w_q, h_q);

	// Select the pixel that owns the write port this cycle
	always_comb begin
		wr_x   = exe;
		wr_y   = eye;
		wr_sel = 1'b0;
		case (state_q)
			ST_CMD: begin
				wr_sel = func_q == FN_WRITE;
			end
			ST_END: begin
				wr_x   = COORD_W'(ecx_q);
				wr_y   = COORD_W'(ecy_q);
				wr_sel = 1'b1;
			end
			ST_ORUN: begin
				wr_x   = opix.x;
				wr_y   = opix.y;
				wr_sel = opix.valid;
			end
			ST_DWAIT: begin
				wr_x   = ipix.x;
				wr_y   = ipix.y;
				wr_sel = ipix.valid;
			end
			default: wr_sel = 1'b0;
		endcase
	end

	assign wr_on     = in_frame(wr_x, wr_y, w_q, h_q);
	assign addr_full = PROD_W'(wr_y[XY_W-1:0] * w_q) + PROD_W'(wr_x[XY_W-1:0]);
	assign addr      = addr_full[ADDR_W-1:0];
	assign ram_we    = wr_sel && wr_on;
	assign ram_re    = (state_q == ST_CMD) && (func_q == FN_READ) && wr_on;

	bsr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (FB_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (color_q),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// Main stroke line
	assign odx     = {ex_q[IN_W-1], ex_q} - {sx_q[IN_W-1], sx_q};
	assign ody     = {ey_q[IN_W-1], ey_q} - {sy_q[IN_W-1], sy_q};
	assign o_start = state_q == ST_OSTRT;
	assign brush_hit = wr_on && brush_q && (r_q != '0);
	assign o_adv   = (state_q == ST_DEND) ||
		((state_q == ST_ORUN) && opix.valid && !brush_hit);

	bsr_line_step u_outer (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (o_start),
		.sx     (sxe),
		.sy     (sye),
		.dx     (odx),
		.dy     (ody),
		.adv    (o_adv),
		.busy   (o_busy),
		.pix    (opix),
		.div_o  (o_div),
		.div_i  (div_rsp)
	);

	// Disc spoke from an octant point back to the centre
	assign omx = oct_q[2] ? b_q : a_q;
	assign omy = oct_q[2] ? a_q : b_q;
	assign ox  = oct_q[0] ? -$signed(COORD_W'(omx)) : $signed(COORD_W'(omx));
	assign oy  = oct_q[1] ? -$signed(COORD_W'(omy)) : $signed(COORD_W'(omy));
	assign isx = $signed(COORD_W'(cx_q)) + ox;
	assign isy = $signed(COORD_W'(cy_q)) + oy;
	assign idx = -DELTA_W'(ox);
	assign idy = -DELTA_W'(oy);
	assign i_start = (state_q == ST_DLINE) && (b_q >= a_q);

	bsr_line_step u_inner (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (i_start),
		.sx     (isx),
		.sy     (isy),
		.dx     (idx),
		.dy     (idy),
		.adv    (1'b1),
		.busy   (i_busy),
		.pix    (ipix),
		.div_o  (i_div),
		.div_i  (div_rsp)
	);

	// Only one line ever waits on the divider
	assign div_req = i_div.req ? i_div : o_div;

	bsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Midpoint circle decision updates
	assign d_dec = d_q + DISC_D_W'(DISC_MUL) *
		($signed(DISC_D_W'(a_q)) - $signed(DISC_D_W'(b_q))) + DISC_D_W'(DISC_DEC);
	assign d_inc = d_q + DISC_D_W'(DISC_MUL) * $signed(DISC_D_W'(a_q)) +
		DISC_D_W'(DISC_INC);

	// Command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CMD;
					end
				end
				ST_CMD: begin
					case (func_q)
						FN_STROKE: state_q <= (!zero_len && end_on) ? ST_END : ST_DONE;
						FN_READ:   state_q <= ST_RD;
						default:   state_q <= ST_DONE;
					endcase
				end
				ST_RD:    state_q <= ST_DONE;
				ST_END:   state_q <= ST_OSTRT;
				ST_OSTRT: state_q <= ST_ORUN;
				ST_ORUN: begin
					if (!o_busy) begin
						state_q <= ST_DONE;
					end else if (opix.valid && brush_hit) begin
						state_q <= ST_DINIT;
					end
				end
				ST_DINIT: state_q <= ST_DLINE;
				ST_DLINE: state_q <= (b_q >= a_q) ? ST_DWAIT : ST_DEND;
				ST_DWAIT: begin
					if (!i_busy) begin
						state_q <= (oct_q == 3'd7) ? ST_DSTEP : ST_DLINE;
					end
				end
				ST_DSTEP: state_q <= ST_DLINE;
				ST_DEND:  state_q <= ST_ORUN;
				ST_DONE:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Command, disc and result registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			func_q  <= func;
			ex_q    <= end_x;
			ey_q    <= end_y;
			sx_q    <= start_x;
			sy_q    <= start_y;
			r_q     <= brush_radius;
			brush_q <= brush_enable;
			color_q <= color;
		end
		if (state_q == ST_CMD) begin
			ecx_q    <= ecx[XY_W-1:0];
			ecy_q    <= ecy[XY_W-1:0];
			rd_on_q  <= wr_on;
			result_q <= '0;
		end
		if (state_q == ST_RD) begin
			result_q <= rd_on_q ? ram_rdata : '0;
		end
		if (state_q == ST_DINIT) begin
			cx_q  <= opix.x[XY_W-1:0];
			cy_q  <= opix.y[XY_W-1:0];
			a_q   <= '0;
			b_q   <= AB_W'(r_q);
			d_q   <= DISC_D_W'(DISC_D0) - DISC_D_W'(2) * DISC_D_W'(r_q);
			oct_q <= '0;
		end
		if ((state_q == ST_DWAIT) && !i_busy) begin
			oct_q <= oct_q + 1'b1;
		end
		if (state_q == ST_DSTEP) begin
			if (d_q > 0) begin
				d_q <= d_dec;
				b_q <= b_q - 1'b1;
			end else begin
				d_q <= d_inc;
			end
			a_q <= a_q + 1'b1;
		end
	end

	assign busy       = state_q != ST_IDLE;
	assign done       = state_q == ST_DONE;
	assign read_value = result_q;

	// Checks
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted command did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block still busy after result beat");
	a_div_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(o_div.req && i_div.req)) else $error("both lines requesting the divider");
	a_zero_val: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (func_q != FN_READ)) |-> (read_value == '0))
		else $error("non-read command returned a pixel value");

endmodule

@@ hw/rtl/bsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module bsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/bsr_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on bsr_pkg for widths and the request/response structs.
module bsr_div
	import bsr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(MAG_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] num_q;
	logic [MAG_W-1:0] den_q;
	logic [MAG_W:0]   rem_q;
	logic [MAG_W:0]   trial;
	logic             ge;
	logic             accept;

	assign accept = req.req && !busy_q && !done_q;
	assign trial  = {rem_q[MAG_W-1:0], num_q[MAG_W-1]};
	assign ge     = trial >= {1'b0, den_q};

	// Control: run MAG_W iterations, then pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MAG_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (accept) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			num_q <= {num_q[MAG_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q;
	assign rsp.rem  = rem_q[MAG_W-1:0];

endmodule

@@ hw/rtl/bsr_line_step.sv @@
// Two-pass DDA line stepper: an x-stepping pass, then a y-stepping pass.
// Depends on bsr_pkg; borrows the shared divider for each pass's step.
module bsr_line_step
	import bsr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [COORD_W-1:0] sx,
	input  logic signed [COORD_W-1:0] sy,
	input  logic signed [DELTA_W-1:0] dx,
	input  logic signed [DELTA_W-1:0] dy,
	input  logic                      adv,
	output logic                      busy,
	output pix_t                      pix,
	output div_req_t                  div_o,
	input  div_rsp_t                  div_i
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [1:0]                st_q;
	logic                      phase_q;
	logic signed [COORD_W-1:0] sx_q, sy_q;
	logic                      negx_q, negy_q;
	logic [MAG_W-1:0]          adx_q, ady_q;
	logic [MAG_W-1:0]          i_q, q_q, acc_q, k_q, rem_q;

	logic [MAG_W-1:0]          adx_in, ady_in;
	logic [MAG_W-1:0]          main_mag, oth_mag;
	logic                      main_neg, oth_neg;
	logic signed [COORD_W-1:0] main_s, oth_s, main_c, oth_c;
	logic [MAG_W:0]            acc_sum;
	logic                      wrap;
	logic [MAG_W-1:0]          acc_nx, q_nx;
	logic signed [DELTA_W-1:0] ndx, ndy;

	assign ndx    = -dx;
	assign ndy    = -dy;
	assign adx_in = dx[DELTA_W-1] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
	assign ady_in = dy[DELTA_W-1] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];

	// Pick the stepping and the following axis for the current pass
	assign main_mag = phase_q ? ady_q : adx_q;
	assign oth_mag  = phase_q ? adx_q : ady_q;
	assign main_neg = phase_q ? negy_q : negx_q;
	assign oth_neg  = phase_q ? negx_q : negy_q;
	assign main_s   = phase_q ? sy_q : sx_q;
	assign oth_s    = phase_q ? sx_q : sy_q;

	assign main_c = main_neg ? main_s - COORD_W'(i_q) : main_s + COORD_W'(i_q);
	assign oth_c  = oth_neg ? oth_s - COORD_W'(q_q) : oth_s + COORD_W'(q_q);

	// Exact truncating quotient, advanced by whole part plus carried remainder
	assign acc_sum = {1'b0, acc_q} + {1'b0, rem_q};
	assign wrap    = acc_sum >= {1'b0, main_mag};
	assign acc_nx  = wrap ? MAG_W'(acc_sum - {1'b0, main_mag}) : acc_sum[MAG_W-1:0];
	assign q_nx    = q_q + k_q + MAG_W'(wrap);

	assign pix.valid = st_q == ST_RUN;
	assign pix.x     = phase_q ? oth_c : main_c;
	assign pix.y     = phase_q ? main_c : oth_c;

	assign div_o.req = st_q == ST_DIV;
	assign div_o.num = oth_mag;
	assign div_o.den = main_mag;

	assign busy = st_q != ST_IDLE;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						if (adx_in != '0) begin
							phase_q <= 1'b0;
							st_q    <= ST_DIV;
						end else if (ady_in != '0) begin
							phase_q <= 1'b1;
							st_q    <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_i.done) begin
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (adv && (i_q == main_mag - 1'b1)) begin
						if (!phase_q && (ady_q != '0)) begin
							phase_q <= 1'b1;
							st_q    <= ST_DIV;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Line and step registers
	always_ff @(posedge clk) begin
		if ((st_q == ST_IDLE) && start) begin
			sx_q   <= sx;
			sy_q   <= sy;
			negx_q <= dx[DELTA_W-1];
			negy_q <= dy[DELTA_W-1];
			adx_q  <= adx_in;
			ady_q  <= ady_in;
		end
		if ((st_q == ST_DIV) && div_i.done) begin
			k_q   <= div_i.quo;
			rem_q <= div_i.rem;
			i_q   <= '0;
			q_q   <= '0;
			acc_q <= '0;
		end else if ((st_q == ST_RUN) && adv) begin
			i_q   <= i_q + 1'b1;
			q_q   <= q_nx;
			acc_q <= acc_nx;
		end
	end

endmodule

@@ tb/bsr_checker.sv @@
// Checker for the brush stroke rasteriser: watches the command, result and
// register ports, keeps its own frame store and compares every read_value beat.
// Depends on bsr_pkg only.
module bsr_checker
	import bsr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic                   done,
	input  logic [1:0]             func,
	input  logic signed [IN_W-1:0] end_x,
	input  logic signed [IN_W-1:0] end_y,
	input  logic signed [IN_W-1:0] start_x,
	input  logic signed [IN_W-1:0] start_y,
	input  logic [RAD_W-1:0]       brush_radius,
	input  logic                   brush_enable,
	input  logic [PIX_W-1:0]       color,
	input  logic [PIX_W-1:0]       read_value,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [SIZE_W-1:0]      cfg_data,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [PIX_W-1:0] canvas [0:MAX_WIDTH*MAX_HEIGHT-1];
	logic [PIX_W-1:0] read_q [$];
	int canvas_w;
	int canvas_h;

	function automatic int clamp_size(input int v, input int mx);
		if (v < 1) begin
			return 1;
		end
		return (v > mx) ? mx : v;
	endfunction

	function automatic bit on_canvas(input int x, input int y);
		return x >= 0 && x < canvas_w && y >= 0 && y < canvas_h;
	endfunction

	function automatic void plot(input int x, input int y, input logic [PIX_W-1:0] c);
		if (on_canvas(x, y)) begin
			canvas[y * canvas_w + x] = c;
		end
	endfunction

	// Two DDA passes, end point painted on its own
	function automatic void draw_stroke(input int ex, input int ey, input int sx,
		input int sy, input int r, input logic [PIX_W-1:0] c, input bit brush);
		int dx, dy, adx, ady, px, py;
		dx = ex - sx;
		dy = ey - sy;
		if (dx == 0 && dy == 0) begin
			return;
		end
		if (on_canvas(sx, sy)) begin
			if (ex < 0) ex = 0; else if (ex >= canvas_w) ex = canvas_w - 1;
			if (ey < 0) ey = 0; else if (ey >= canvas_h) ey = canvas_h - 1;
		end
		if (!on_canvas(ex, ey)) begin
			return;
		end
		plot(ex, ey, c);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		for (int i = 0; i < adx; i++) begin
			py = sy + (dy * i) / adx;
			px = dx < 0 ? sx - i : sx + i;
			if (on_canvas(px, py)) begin
				plot(px, py, c);
				if (brush && r > 0) stamp_disc(px, py, r, c);
			end
		end
		for (int i = 0; i < ady; i++) begin
			px = sx + (dx * i) / ady;
			py = dy < 0 ? sy - i : sy + i;
			if (on_canvas(px, py)) begin
				plot(px, py, c);
				if (brush && r > 0) stamp_disc(px, py, r, c);
			end
		end
	endfunction

	// Midpoint circle: spokes from the eight octant points back to the centre
	function automatic void stamp_disc(input int cx, input int cy, input int r,
		input logic [PIX_W-1:0] c);
		int a, b, d;
		a = 0;
		b = r;
		d = DISC_D0 - 2 * r;
		while (b >= a) begin
			draw_stroke(cx, cy, cx + a, cy + b, r, c, 0);
			draw_stroke(cx, cy, cx - a, cy + b, r, c, 0);
			draw_stroke(cx, cy, cx + a, cy - b, r, c, 0);
			draw_stroke(cx, cy, cx - a, cy - b, r, c, 0);
			draw_stroke(cx, cy, cx + b, cy + a, r, c, 0);
			draw_stroke(cx, cy, cx - b, cy + a, r, c, 0);
			draw_stroke(cx, cy, cx + b, cy - a, r, c, 0);
			draw_stroke(cx, cy, cx - b, cy - a, r, c, 0);
			if (d > 0) begin
				d = d + DISC_MUL * (a - b) + DISC_DEC;
				b--;
			end else begin
				d = d + DISC_MUL * a + DISC_INC;
			end
			a++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [PIX_W-1:0] want;
		int ex, ey, r;
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH * MAX_HEIGHT; i++) canvas[i] = '0;
			read_q.delete();
			canvas_w = MAX_WIDTH;
			canvas_h = MAX_HEIGHT;
			fail_count = 0;
			pending = 0;
		end else begin
			// compare a result beat with the oldest expectation
			if (done) begin
				if (read_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, read_value %h",
						$realtime, read_value);
					fail_count++;
				end else begin
					want = read_q.pop_front();
					if (read_value !== want) begin
						$display("%0t: read_value expected %h actual %h",
							$realtime, want, read_value);
						fail_count++;
					end
				end
			end
			// track register writes
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH) begin
					canvas_w = clamp_size(int'(cfg_data), MAX_WIDTH);
				end else begin
					canvas_h = clamp_size(int'(cfg_data), MAX_HEIGHT);
				end
			end
			// predict an accepted command
			if (start && !busy) begin
				ex = end_x;
				ey = end_y;
				r = (int'(brush_radius) > MAX_RADIUS) ? MAX_RADIUS : int'(brush_radius);
				want = '0;
				case (func)
					FN_STROKE: begin
						draw_stroke(ex, ey, int'(start_x), int'(start_y), r, color,
							brush_enable);
					end
					FN_WRITE: begin
						plot(ex, ey, color);
					end
					FN_READ: begin
						if (on_canvas(ex, ey)) want = canvas[ey * canvas_w + ex];
					end
					default: begin
					end
				endcase
				read_q.push_back(want);
			end
			pending = read_q.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// Top of the brush stroke rasteriser testbench: clock, reset, command and
// register stimulus, verdict. Depends on bsr_pkg, bsr_checker and the RTL top.
module testbench;
	import bsr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FN_IDLE = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic                   done;
	logic [1:0]             func = FN_STROKE;
	logic signed [IN_W-1:0] end_x = '0;
	logic signed [IN_W-1:0] end_y = '0;
	logic signed [IN_W-1:0] start_x = '0;
	logic signed [IN_W-1:0] start_y = '0;
	logic [RAD_W-1:0]       brush_radius = '0;
	logic                   brush_enable = 1'b0;
	logic [PIX_W-1:0]       color = '0;
	logic [PIX_W-1:0]       read_value;
	logic                   cfg_we = 1'b0;
	logic                   cfg_index = REG_WIDTH;
	logic [SIZE_W-1:0]      cfg_data = '0;
	int                     fail_count;
	int                     pending;

	// frame size as the block sees it, and addresses written by pixel writes
	int size_w = MAX_WIDTH;
	int size_h = MAX_HEIGHT;
	int written_addr [$];
	bit no_gaps = 0;

	brush_stroke_rasterizer_top i_dut (.*);

	bsr_checker i_checker (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("FAIL");
		$finish;
	end

	// present one command and hold it until the block takes it
	task automatic issue(input logic [1:0] f, input int ex, input int ey, input int sx,
		input int sy, input int r, input bit br, input logic [PIX_W-1:0] c);
		func <= f;
		end_x <= IN_W'(ex);
		end_y <= IN_W'(ey);
		start_x <= IN_W'(sx);
		start_y <= IN_W'(sy);
		brush_radius <= RAD_W'(r);
		brush_enable <= br;
		color <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (f == FN_WRITE && ex >= 0 && ex < size_w && ey >= 0 && ey < size_h) begin
			written_addr.push_back(ey * size_w + ex);
		end
		// random gap after the beat
		if (!no_gaps && $urandom_range(99) < 16) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// read a pixel known to be written, or an off-frame one
	task automatic read_back();
		int a;
		for (int t = 0; t < 8 && written_addr.size() > 0; t++) begin
			a = written_addr[$urandom_range(written_addr.size() - 1)];
			if (a < size_w * size_h) begin
				issue(FN_READ, a % size_w, a / size_w, $urandom_range(4095) - 2048,
					$urandom_range(4095) - 2048, $urandom_range(63), $urandom_range(1),
					$urandom);
				return;
			end
		end
		issue(FN_READ, -1 - $urandom_range(2047), $urandom_range(4095) - 2048, 0, 0, 0, 0,
			$urandom);
	endtask

	// drain the block, then write one register
	task automatic set_size(input logic idx, input int v);
		start <= 1'b0;
		// let the checker count the last accepted beat first
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= SIZE_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH) begin
			size_w = (v < 1) ? 1 : (v > MAX_WIDTH ? MAX_WIDTH : v);
		end else begin
			size_h = (v < 1) ? 1 : (v > MAX_HEIGHT ? MAX_HEIGHT : v);
		end
	endtask

	function automatic int near_x();
		return $urandom_range(size_w + 12) - 6;
	endfunction

	function automatic int near_y();
		return $urandom_range(size_h + 12) - 6;
	endfunction

	task automatic random_item(input int n);
		int kind, sx, sy;
		kind = $urandom_range(99);
		if (kind < 28) begin
			issue(FN_WRITE, near_x(), near_y(), $urandom_range(4095) - 2048,
				$urandom_range(4095) - 2048, $urandom_range(63), $urandom_range(1), $urandom);
		end else if (kind < 45) begin
			read_back();
		end else if (kind < 62) begin
			issue(FN_STROKE, near_x(), near_y(), near_x(), near_y(), $urandom_range(63), 0,
				$urandom);
		end else if (kind < 72) begin
			// long strokes across the whole coordinate range
			issue(FN_STROKE, $urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
				$urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
				$urandom_range(63), 0, $urandom);
		end else if (kind < 92) begin
			// short brushed strokes near the frame
			sx = near_x();
			sy = near_y();
			issue(FN_STROKE, sx + $urandom_range(8) - 4, sy + $urandom_range(8) - 4, sx, sy,
				$urandom_range(4), 1, $urandom);
		end else begin
			issue(FN_IDLE, $urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
				$urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
				$urandom_range(63), $urandom_range(1), $urandom);
		end
		// hold off until the block has caught up
		if (n == 40) begin
			start <= 1'b0;
			@(posedge clk);
			wait (pending == 0);
			@(posedge clk);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pixel extremes, off-frame access, unused code
		issue(FN_WRITE, 0, 0, 0, 0, 0, 0, 32'h0000_0000);
		issue(FN_WRITE, 255, 255, 0, 0, 0, 0, 32'hFFFF_FFFF);
		issue(FN_READ, 0, 0, 0, 0, 0, 0, 32'h0);
		issue(FN_READ, 255, 255, 0, 0, 0, 0, 32'h0);
		issue(FN_WRITE, -2048, 2047, 0, 0, 0, 0, 32'hDEAD_BEEF);
		issue(FN_READ, 2047, -2048, 0, 0, 0, 0, 32'h0);
		issue(FN_IDLE, 2047, 2047, 2047, 2047, 63, 1, 32'hFFFF_FFFF);
		// zero-length stroke, start on with end off (clamp), both off, start off
		issue(FN_STROKE, 40, 40, 40, 40, 3, 1, 32'h1111_1111);
		issue(FN_STROKE, 2047, -2048, 10, 20, 0, 0, 32'h2222_2222);
		issue(FN_STROKE, -2048, 2047, 2047, -2048, 0, 0, 32'h3333_3333);
		issue(FN_STROKE, 30, 5, -20, -9, 0, 0, 32'h4444_4444);
		issue(FN_STROKE, 5, 200, 300, 180, 0, 0, 32'h5555_5555);
		// a shallow and a steep line
		issue(FN_STROKE, 100, 7, 3, 90, 0, 0, 32'h6666_6666);
		issue(FN_STROKE, 60, 120, 61, 20, 0, 0, 32'h7777_7777);
		// brushes: radius zero, largest radius, disc over the frame edge
		issue(FN_STROKE, 51, 50, 50, 50, 0, 1, 32'h8888_8888);
		issue(FN_STROKE, 128, 129, 128, 128, 63, 1, 32'h9999_9999);
		issue(FN_STROKE, 2, 1, 0, 0, 5, 1, 32'hAAAA_AAAA);
		issue(FN_STROKE, 250, 255, 255, 250, 7, 1, 32'hBBBB_BBBB);
		issue(FN_READ, 0, 0, 0, 0, 0, 0, 32'h0);
		issue(FN_READ, 255, 255, 0, 0, 0, 0, 32'h0);

		// random phases over several frame sizes, extremes included
		for (int n = 0; n < 70; n++) random_item(n);
		set_size(REG_WIDTH, 0);
		set_size(REG_HEIGHT, 511);
		for (int n = 0; n < 50; n++) random_item(n);
		set_size(REG_WIDTH, 256);
		set_size(REG_HEIGHT, 1);
		no_gaps = 1;
		for (int n = 0; n < 50; n++) random_item(n);
		no_gaps = 0;
		set_size(REG_WIDTH, 37);
		set_size(REG_HEIGHT, 150);
		for (int n = 0; n < 60; n++) random_item(n);
		set_size(REG_WIDTH, 1);
		set_size(REG_HEIGHT, 1);
		for (int n = 0; n < 10; n++) random_item(n);
		set_size(REG_WIDTH, 511);
		set_size(REG_HEIGHT, 256);
		for (int n = 0; n < 50; n++) random_item(n);
		start <= 1'b0;

		// drain and settle
		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
